>>> rtl/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

	typedef enum logic [1:0] {
		PH_PLAIN  = 2'd0,
		PH_ESCAPE = 2'd1,
		PH_HEX    = 2'd2
	} phase_t;

	// Characters with special meaning in a string body
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam int RunMax = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		logic       bad_escape;
	} result_t;

	// Results caused by one input item; count is 0..3
	typedef struct packed {
		logic [1:0]             count;
		result_t [RunMax-1:0]   res;
	} run_t;

endpackage
`default_nettype wire

>>> rtl/jsu_decode.sv
`default_nettype none
module jsu_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    in_byte,
	input  wire logic          end_of_data,
	output jsu_pkg::run_t      run
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  digits_q, digits_d;
	logic [11:0] cp_q, cp_d;
	logic [15:0] cp_full;
	logic        is_hex;
	logic [3:0]  hex_val;

	function automatic result_t mk(input logic [7:0] b, input logic v,
	                               input logic e, input logic bad);
		result_t r;
		r.out_byte   = b;
		r.byte_valid = v;
		r.string_end = e;
		r.bad_escape = bad;
		return r;
	endfunction

	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
		             (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
			hex_val = in_byte[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	assign cp_full = {cp_q, hex_val};

	always_comb begin
		phase_d  = phase_q;
		digits_d = digits_q;
		cp_d     = cp_q;
		run      = '0;
		case (phase_q)
			PH_ESCAPE: begin
				phase_d   = PH_PLAIN;
				run.count = 2'd1;
				if (end_of_data) begin
					run.res[0] = mk(8'h00, 1'b0, 1'b0, 1'b1);
				end else begin
					case (in_byte)
						CH_QUOTE:  run.res[0] = mk(CH_QUOTE, 1'b1, 1'b0, 1'b0);
						CH_BSLASH: run.res[0] = mk(CH_BSLASH, 1'b1, 1'b0, 1'b0);
						CH_SLASH:  run.res[0] = mk(CH_SLASH, 1'b1, 1'b0, 1'b0);
						CH_B:      run.res[0] = mk(8'h08, 1'b1, 1'b0, 1'b0);
						CH_F:      run.res[0] = mk(8'h0C, 1'b1, 1'b0, 1'b0);
						CH_N:      run.res[0] = mk(8'h0A, 1'b1, 1'b0, 1'b0);
						CH_R:      run.res[0] = mk(8'h0D, 1'b1, 1'b0, 1'b0);
						CH_T:      run.res[0] = mk(8'h09, 1'b1, 1'b0, 1'b0);
						CH_U: begin
							phase_d   = PH_HEX;
							digits_d  = 2'd0;
							cp_d      = '0;
							run.count = 2'd0;
						end
						default:   run.res[0] = mk(8'h00, 1'b0, 1'b0, 1'b1);
					endcase
				end
			end
			PH_HEX: begin
				if (end_of_data || !is_hex) begin
					phase_d    = PH_PLAIN;
					digits_d   = 2'd0;
					cp_d       = '0;
					run.count  = 2'd1;
					run.res[0] = mk(8'h00, 1'b0, 1'b0, 1'b1);
				end else if (digits_q != 2'd3) begin
					cp_d     = cp_full[11:0];
					digits_d = digits_q + 2'd1;
				end else begin
					phase_d  = PH_PLAIN;
					digits_d = 2'd0;
					cp_d     = '0;
					if (cp_full[15:7] == '0) begin
						run.count  = 2'd1;
						run.res[0] = mk(cp_full[7:0], 1'b1, 1'b0, 1'b0);
					end else if (cp_full[15:11] == '0) begin
						run.count  = 2'd2;
						run.res[0] = mk({3'b110, cp_full[10:6]}, 1'b1, 1'b0, 1'b0);
						run.res[1] = mk({2'b10, cp_full[5:0]}, 1'b1, 1'b0, 1'b0);
					end else begin
						run.count  = 2'd3;
						run.res[0] = mk({4'b1110, cp_full[15:12]}, 1'b1, 1'b0, 1'b0);
						run.res[1] = mk({2'b10, cp_full[11:6]}, 1'b1, 1'b0, 1'b0);
						run.res[2] = mk({2'b10, cp_full[5:0]}, 1'b1, 1'b0, 1'b0);
					end
				end
			end
			default: begin
				// plain phase; the unused code acts the same
				phase_d = PH_PLAIN;
				if (end_of_data || in_byte == CH_QUOTE) begin
					run.count  = 2'd1;
					run.res[0] = mk(8'h00, 1'b0, 1'b1, 1'b0);
				end else if (in_byte == CH_BSLASH) begin
					phase_d = PH_ESCAPE;
				end else begin
					run.count  = 2'd1;
					run.res[0] = mk(in_byte, 1'b1, 1'b0, 1'b0);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PLAIN;
			digits_q <= 2'd0;
			cp_q     <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			digits_q <= digits_d;
			cp_q     <= cp_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/jsu_serializer.sv
`default_nettype none
module jsu_serializer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire jsu_pkg::run_t run,
	output logic               can_load,
	output logic               out_valid,
	input  wire logic          out_stall,
	output jsu_pkg::result_t   res,
	output logic               last
);
	import jsu_pkg::*;

	logic       s1_valid_s1;
	run_t       run_s1;
	logic       out_valid_q;
	run_t       run_q;
	logic [1:0] idx_q;
	logic       out_done, out_free, s1_move;

	assign res       = run_q.res[idx_q];
	assign last      = (idx_q == run_q.count - 2'd1);
	assign out_valid = out_valid_q;
	assign out_done  = out_valid_q && !out_stall && last;
	assign out_free  = !out_valid_q || out_done;
	assign s1_move   = s1_valid_s1 && out_free;
	assign can_load  = !s1_valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (out_done) begin
				out_valid_q <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_s1 <= run;
		end
		if (s1_move) begin
			run_q <= run_s1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/json_string_unescaper.sv
`default_nettype none
// JSON string body unescaper. Feed the bytes of a string body, one per input
// transfer, starting after the opening quote; end_of_data=1 marks that no byte
// is available. Each input transfer yields zero to three output transfers:
// a backslash, the 'u' of \u and the first three hex digits give none, the
// fourth hex digit gives the UTF-8 encoding of the code point (1, 2 or 3
// bytes, surrogates not paired), and everything else gives one. A closing
// quote or end of data gives one transfer with only string_end set; a bad
// escape letter, a non-hex digit or data ending inside an escape gives one
// with only bad_escape set. Both return to the plain state. out_byte is 0
// when byte_valid is 0, and last_of_run marks the final transfer of an input.
// Throughput: one input per cycle while each input yields at most one
// result and the output is not stalled; an input that yields several results
// holds the single output register until its last transfer is taken. A
// decoded run passes through the stage register, then the output register,
// before its first output transfer. One decoded run may wait behind a stalled output before input stalls.
module json_string_unescaper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             string_end,
	output logic             bad_escape,
	output logic             last_of_run
);
	import jsu_pkg::*;

	run_t    run;
	result_t res;
	logic    can_load;
	logic    accept;
	logic    last;

	// Input transfer updates the escape state and, if it has results,
	// loads the decoded run into the stage register.
	assign in_stall = !can_load;
	assign accept   = in_valid && can_load;

	jsu_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (in_byte),
		.end_of_data (end_of_data),
		.run         (run)
	);

	jsu_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && run.count != 2'd0),
		.run       (run),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.last      (last)
	);

	assign out_byte    = res.out_byte;
	assign byte_valid  = res.byte_valid;
	assign string_end  = res.string_end;
	assign bad_escape  = res.bad_escape;
	assign last_of_run = last;

endmodule
`default_nettype wire
